>>> src/mscrc_pkg.sv
// Shared types, codes and standard parameter table for the multi-standard CRC engine.
`default_nettype none

package mscrc_pkg;

  localparam int unsigned CrcW     = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned ShiftW   = 6;

  // Standard selector codes
  localparam logic [ModeW-1:0] MODE_CRC8_J1850 = 3'd0;
  localparam logic [ModeW-1:0] MODE_CRC8H2F    = 3'd1;
  localparam logic [ModeW-1:0] MODE_CRC16_CCIT = 3'd2;
  localparam logic [ModeW-1:0] MODE_CRC16_ARC  = 3'd3;
  localparam logic [ModeW-1:0] MODE_CRC32      = 3'd4;
  localparam logic [ModeW-1:0] MODE_CRC32P4    = 3'd5;
  localparam logic [ModeW-1:0] MODE_CRC64      = 3'd6;

  // Request kinds
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic [CrcW-1:0]   poly;
    logic [CrcW-1:0]   init;
    logic [CrcW-1:0]   xorout;
    logic [CrcW-1:0]   mask;
    logic [ShiftW-1:0] lshift;    // 64 minus register width
    logic              reflected;
  } crc_std_t;

  function automatic crc_std_t crc_std(input logic [ModeW-1:0] mode);
    crc_std_t s;
    unique case (mode)
      MODE_CRC8_J1850: begin
        s = '{poly: 64'h1D, init: 64'hFF, xorout: 64'hFF, mask: 64'hFF,
              lshift: 6'd56, reflected: 1'b0};
      end
      MODE_CRC8H2F: begin
        s = '{poly: 64'h2F, init: 64'hFF, xorout: 64'hFF, mask: 64'hFF,
              lshift: 6'd56, reflected: 1'b0};
      end
      MODE_CRC16_CCIT: begin
        s = '{poly: 64'h1021, init: 64'hFFFF, xorout: 64'h0, mask: 64'hFFFF,
              lshift: 6'd48, reflected: 1'b0};
      end
      MODE_CRC16_ARC: begin
        s = '{poly: 64'hA001, init: 64'h0, xorout: 64'h0, mask: 64'hFFFF,
              lshift: 6'd48, reflected: 1'b1};
      end
      MODE_CRC32P4: begin
        s = '{poly: 64'hC8DF352F, init: 64'hFFFFFFFF, xorout: 64'hFFFFFFFF,
              mask: 64'hFFFFFFFF, lshift: 6'd32, reflected: 1'b1};
      end
      MODE_CRC64: begin
        s = '{poly: 64'hC96C5795D7870F42, init: 64'hFFFFFFFFFFFFFFFF,
              xorout: 64'hFFFFFFFFFFFFFFFF, mask: 64'hFFFFFFFFFFFFFFFF,
              lshift: 6'd0, reflected: 1'b1};
      end
      default: begin
        // CRC32, also serves the unused selector code
        s = '{poly: 64'hEDB88320, init: 64'hFFFFFFFF, xorout: 64'hFFFFFFFF,
              mask: 64'hFFFFFFFF, lshift: 6'd32, reflected: 1'b1};
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/mscrc_datapath.sv
// Combinational next-state and result logic: load, restart and eight-bit fold.
`default_nettype none

module mscrc_datapath
  import mscrc_pkg::*;
(
  input  crc_std_t              std_sel,
  input  logic                  command,
  input  logic [ByteW-1:0]      data_byte,
  input  logic [CrcW-1:0]       start_value,
  input  logic                  first_call,
  input  logic [CrcW-1:0]       running_crc,
  output logic [CrcW-1:0]       running_next,
  output logic [CrcW-1:0]       crc_result
);

  logic [CrcW-1:0] seed;
  logic [CrcW-1:0] fold_norm;
  logic [CrcW-1:0] fold_refl;
  logic [CrcW-1:0] poly_left;
  logic [CrcW-1:0] folded;

  assign seed = (first_call ? std_sel.init : running_crc) & std_sel.mask;

  // MSB-first standards: left-align to bit 63 so one datapath fits every width
  always_comb begin
    poly_left = std_sel.poly << std_sel.lshift;
    fold_norm = (seed << std_sel.lshift) ^ {data_byte, {(CrcW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      fold_norm = fold_norm[CrcW-1] ? ((fold_norm << 1) ^ poly_left) : (fold_norm << 1);
    end
    fold_norm = fold_norm >> std_sel.lshift;
  end

  // LSB-first standards: polynomial already lies inside the width
  always_comb begin
    fold_refl = seed ^ {{(CrcW-ByteW){1'b0}}, data_byte};
    for (int k = 0; k < ByteW; k++) begin
      fold_refl = fold_refl[0] ? ((fold_refl >> 1) ^ std_sel.poly) : (fold_refl >> 1);
    end
  end

  assign folded = (std_sel.reflected ? fold_refl : fold_norm) & std_sel.mask;

  assign running_next = (command == CMD_LOAD) ? ((start_value ^ std_sel.xorout) & std_sel.mask)
                                              : folded;
  assign crc_result   = (folded ^ std_sel.xorout) & std_sel.mask;

endmodule

`default_nettype wire

>>> src/multi_standard_crc_engine_top.sv
// Top level of the multi-standard CRC engine: request register, CRC state and result register.
`default_nettype none

// Byte-serial CRC engine covering CRC8 SAE J1850, CRC8H2F, CRC16 CCITT-FALSE,
// CRC16 ARC, CRC32, CRC32P4 and CRC64, chosen by the three-bit cfg_data register
// (reset selects CRC32; the unused code also acts as CRC32). Each request on the
// slave stream either feeds one byte (tuser[0] low) or loads an earlier finished
// CRC to resume a chained calculation (tuser[0] high, taken from tdata[71:8]).
// tuser[1] restarts the register from the standard's initial value before the
// byte; tlast marks the final byte and makes the engine emit the finished CRC,
// zero-extended to 64 bits, on the master stream. Loads and non-final bytes give
// no output. Rate: one request per clock while the input is not stalled. A
// request is captured in the input register, folded by an eight-step unrolled
// XOR network while held there, and its result lands in the output register.
// The running CRC is updated when that fold is taken, together with the output
// register, which lets the next byte follow immediately. The input stalls only
// while a finished CRC waits in the output register and the request held in
// the input register would produce another one. Write the mode only while the
// engine is idle.
module multi_standard_crc_engine_top
  import mscrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ModeW-1:0]     cfg_data,     // crc_mode
  // Request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,      // [7:0] data_byte, [71:8] start_value
  input  logic [1:0]           s_tuser,      // [0] command, [1] first_call
  input  logic                 s_tlast,      // last_byte
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [CrcW-1:0]      m_tdata       // [63:0] crc_result
);

  // Mode register
  logic [ModeW-1:0] crc_mode;

  // Input register
  logic             in_valid;
  logic             in_cmd;
  logic [ByteW-1:0] in_byte;
  logic [CrcW-1:0]  in_start;
  logic             in_first;
  logic             in_last;

  // CRC state and result register
  logic [CrcW-1:0]  running_crc;
  logic [CrcW-1:0]  running_next;
  logic [CrcW-1:0]  crc_result;
  logic             out_valid;
  logic [CrcW-1:0]  out_data;

  crc_std_t         std_sel;
  logic             produce;
  logic             fire;
  logic             s_accept;

  assign std_sel  = crc_std(crc_mode);
  assign produce  = in_valid && (in_cmd == CMD_FEED) && in_last;
  // Advance the held request unless its result would overwrite one still waiting
  assign fire     = in_valid && (!produce || !out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_accept = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= MODE_CRC32;
    end else if (cfg_valid && cfg_ready) begin
      crc_mode <= cfg_data;
    end
  end

  // Capture the request; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_cmd   <= s_tuser[0];
      in_first <= s_tuser[1];
      in_byte  <= s_tdata[7:0];
      in_start <= s_tdata[71:8];
      in_last  <= s_tlast;
    end
  end

  mscrc_datapath u_datapath (
    .std_sel      (std_sel),
    .command      (in_cmd),
    .data_byte    (in_byte),
    .start_value  (in_start),
    .first_call   (in_first),
    .running_crc  (running_crc),
    .running_next (running_next),
    .crc_result   (crc_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (fire) begin
      running_crc <= running_next;
    end
  end

  // Hold the finished CRC until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && produce) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_data <= crc_result;
    end
  end

  // A waiting result must block a second final byte
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (produce && out_valid && !m_tready) |-> !fire && !s_tready)
    else $error("result register overwritten while stalled");

  // A new result only ever follows a final data byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && !m_tready)) |-> $past(fire && produce))
    else $error("result appeared without a final byte");

  // Loaded start value is trimmed to the standard's width
  a_load_masked: assert property (@(posedge clk) disable iff (rst)
    (fire && in_cmd == CMD_LOAD) |=> ((running_crc & ~$past(std_sel.mask)) == '0))
    else $error("loaded CRC exceeds standard width");

  // Load requests never leave an output
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && in_cmd == CMD_LOAD && !(out_valid && !m_tready)) |=> !out_valid)
    else $error("load request produced a result");

endmodule

`default_nettype wire

>>> test/crc_result_checker.sv
// Checker for the multi-standard CRC engine: watches the channels, predicts each CRC and compares.
`timescale 1ns / 100ps

module crc_result_checker
  import mscrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [ModeW-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [71:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [CrcW-1:0]  m_tdata,
  output int               mismatch_count,
  output int               crc_pending,
  output int               crcs_checked
);

  localparam int PrintCap = 30;

  typedef struct {
    int unsigned     width;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] xorout;
    bit              reflected;
  } crc_param_t;

  logic [CrcW-1:0]  awaited_crc[$];
  logic [ModeW-1:0] active_mode;
  logic [CrcW-1:0]  running_crc;

  initial begin
    mismatch_count = 0;
    crcs_checked   = 0;
    crc_pending    = 0;
  end

  function automatic crc_param_t crc_standard(input logic [ModeW-1:0] mode);
    crc_param_t p;
    case (mode)
      MODE_CRC8_J1850: p = '{8,  64'h1D,   64'hFF,   64'hFF,  1'b0};
      MODE_CRC8H2F:    p = '{8,  64'h2F,   64'hFF,   64'hFF,  1'b0};
      MODE_CRC16_CCIT: p = '{16, 64'h1021, 64'hFFFF, 64'h0,   1'b0};
      MODE_CRC16_ARC:  p = '{16, 64'hA001, 64'h0,    64'h0,   1'b1};
      MODE_CRC32P4:    p = '{32, 64'hC8DF352F, 64'hFFFFFFFF, 64'hFFFFFFFF, 1'b1};
      MODE_CRC64:      p = '{64, 64'hC96C5795D7870F42, '1, '1, 1'b1};
      // CRC32, which the unused code falls back to as well
      default:         p = '{32, 64'hEDB88320, 64'hFFFFFFFF, 64'hFFFFFFFF, 1'b1};
    endcase
    return p;
  endfunction

  function automatic logic [CrcW-1:0] width_mask(input int unsigned width);
    return (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
  endfunction

  // Fold one byte into the register, eight bit steps
  function automatic logic [CrcW-1:0] crc_fold_byte(input crc_param_t p,
                                                     input logic [CrcW-1:0] crc_in,
                                                     input logic [7:0] data_b);
    logic [CrcW-1:0] r;
    logic [CrcW-1:0] msk;
    logic [CrcW-1:0] top_bit;
    msk = width_mask(p.width);
    r = crc_in & msk;
    if (p.reflected) begin
      r ^= {56'd0, data_b};
      for (int k = 0; k < 8; k++)
        r = r[0] ? ((r >> 1) ^ p.poly) : (r >> 1);
    end else begin
      top_bit = 64'd1 << (p.width - 1);
      r ^= {56'd0, data_b} << (p.width - 8);
      for (int k = 0; k < 8; k++)
        r = ((r & top_bit) != 0) ? (((r << 1) ^ p.poly) & msk) : ((r << 1) & msk);
    end
    return r & msk;
  endfunction

  task automatic report_mismatch(input string what, input logic [CrcW-1:0] got,
                                 input logic [CrcW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    crc_param_t      p;
    logic [CrcW-1:0] msk;
    logic [CrcW-1:0] want;
    if (rst) begin
      awaited_crc.delete();
      active_mode = MODE_CRC32;
      running_crc = '0;
      crc_pending <= 0;
    end else begin
      // Compare first: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (awaited_crc.size() == 0) begin
          report_mismatch("result with none awaited", m_tdata, '0);
        end else begin
          want = awaited_crc.pop_front();
          crcs_checked++;
          if (m_tdata !== want)
            report_mismatch("crc_result", m_tdata, want);
        end
      end
      if (s_tvalid && s_tready) begin
        p = crc_standard(active_mode);
        msk = width_mask(p.width);
        if (s_tuser[0] == CMD_LOAD) begin
          running_crc = (s_tdata[71:8] ^ p.xorout) & msk;
        end else begin
          if (s_tuser[1])
            running_crc = p.init;
          running_crc = crc_fold_byte(p, running_crc, s_tdata[7:0]);
          if (s_tlast)
            awaited_crc.push_back((running_crc ^ p.xorout) & msk);
        end
      end
      if (cfg_valid && cfg_ready)
        active_mode = cfg_data;
      crc_pending <= awaited_crc.size();
    end
  end

endmodule

>>> test/multi_standard_crc_engine_top_tb.sv
// Testbench top for the multi-standard CRC engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module multi_standard_crc_engine_top_tb;
  import mscrc_pkg::*;

  localparam logic [ModeW-1:0] ModeUnused = 3'd7;
  localparam int StallLimit  = 2000;  // cycles with nothing moving before giving up
  localparam int HoldCycles  = 100;   // receiver hold-off length
  localparam int PhaseCount  = 13;
  localparam int PhaseItems  = 40;
  localparam int HoldPhase   = 4;
  localparam int QuietPhase  = 9;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [ModeW-1:0] cfg_data;       // crc_mode
  logic             s_tvalid;
  logic             s_tready;
  logic [71:0]      s_tdata;        // [7:0] data_byte, [71:8] start_value
  logic [1:0]       s_tuser;        // [0] command, [1] first_call
  logic             s_tlast;        // last_byte
  logic             m_tvalid;
  logic             m_tready;
  logic [CrcW-1:0]  m_tdata;        // [63:0] crc_result

  int mismatch_count;
  int crc_pending;
  int crcs_checked;

  // Stimulus bookkeeping for the summary and phase lengths, and the watchdog's stall count
  int requests_sent;
  int loads_sent;
  int frames_sent;
  int stalled_cycles;

  // Shared between the request and result processes
  bit gaps_on;
  int hold_asks;

  logic [ModeW-1:0] mode_plan [PhaseCount] = '{
    MODE_CRC8_J1850, MODE_CRC64, MODE_CRC8H2F, MODE_CRC16_CCIT, MODE_CRC32,
    MODE_CRC16_ARC, MODE_CRC32P4, ModeUnused, MODE_CRC64, MODE_CRC8_J1850,
    MODE_CRC16_ARC, MODE_CRC32P4, MODE_CRC16_CCIT
  };

  multi_standard_crc_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  crc_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .crc_pending    (crc_pending),
    .crcs_checked   (crcs_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if no request, result or register write moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= StallLimit) begin
      $display("Timeout: nothing accepted for %0d cycles", StallLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Result side: accept at random, hold off completely when asked, else stay ready
  initial begin : result_sink
    int hold_taken;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_taken) begin
        // Hold off long enough for the engine to fill up and stall its input
        hold_taken = hold_asks;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!gaps_on || rst) begin
        m_tready <= !rst;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Offer one request; idle at random first, then hold it until the engine takes it
  task automatic put_request(input logic cmd, input logic [7:0] data_b,
                             input logic [63:0] resume_val, input logic is_first,
                             input logic is_last);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {resume_val, data_b};
    s_tuser  <= {is_first, cmd};
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (cmd == CMD_LOAD)
      loads_sent++;
  endtask

  // A message of random bytes; restart on its first byte or carry on from the register
  task automatic send_frame(input int len, input bit restart);
    for (int i = 0; i < len; i++)
      put_request(CMD_FEED, 8'($urandom), {$urandom, $urandom}, restart && (i == 0),
                  i == len - 1);
    frames_sent++;
  endtask

  // A load with every ignored field random
  task automatic send_load(input logic [63:0] resume_val);
    put_request(CMD_LOAD, 8'($urandom), resume_val, 1'($urandom), 1'($urandom));
  endtask

  // Change the standard only once the engine has drained
  task automatic set_mode(input logic [ModeW-1:0] mode);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (crc_pending != 0);
    // allow a load or a non-final byte still inside the pipeline to settle
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_start;
    int pick;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    gaps_on   = 1'b1;
    hold_asks = 0;
    requests_sent = 0;
    loads_sent    = 0;
    frames_sent   = 0;
    stalled_cycles = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset standard is CRC32 and the register starts from zero
    put_request(CMD_FEED, 8'h00, '0, 1'b0, 1'b1);       // no first byte since reset
    put_request(CMD_FEED, 8'hFF, '1, 1'b1, 1'b1);
    send_load('1);                                      // resume from all ones
    put_request(CMD_FEED, 8'hA5, '0, 1'b0, 1'b1);
    put_request(CMD_LOAD, 8'hFF, '0, 1'b1, 1'b1);       // load ignores first and last
    put_request(CMD_FEED, 8'h00, '1, 1'b0, 1'b1);

    // Switch standard mid-message: the running register keeps its bits
    set_mode(MODE_CRC64);
    put_request(CMD_FEED, 8'hFF, '0, 1'b1, 1'b0);
    put_request(CMD_FEED, 8'h00, '1, 1'b0, 1'b0);
    set_mode(MODE_CRC8_J1850);
    put_request(CMD_FEED, 8'h5A, '0, 1'b0, 1'b1);
    send_load(64'hFFFF_FFFF_FFFF_FF00);                 // high bits beyond width dropped
    put_request(CMD_FEED, 8'h80, '0, 1'b0, 1'b1);

    // Unused code falls back to CRC32
    set_mode(ModeUnused);
    put_request(CMD_FEED, 8'h31, '0, 1'b1, 1'b1);
    send_load(64'hFFFF_FFFF_0000_0000);
    put_request(CMD_FEED, 8'h7E, '0, 1'b0, 1'b1);

    // Random: mostly well-formed messages, some chained resumes, some noise
    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_mode(mode_plan[ph]);
      gaps_on = (ph != QuietPhase) && (ph != HoldPhase);
      if (ph == HoldPhase) begin
        // Keep offering single-byte messages while the receiver holds off
        hold_asks++;
        repeat (24) send_frame(1, 1'b1);
      end
      phase_start = requests_sent;
      while (requests_sent - phase_start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_frame($urandom_range(1, 8), 1'b1);
        end else if (pick < 75) begin
          send_load({$urandom, $urandom});
          send_frame($urandom_range(1, 6), 1'b0);
        end else if (pick < 85) begin
          send_frame($urandom_range(1, 4), 1'b0);
        end else begin
          put_request(1'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom),
                      1'($urandom));
        end
      end
    end
    gaps_on = 1'b1;

    // Drain: wait for every awaited CRC, then for any stray output
    s_tvalid <= 1'b0;
    do @(posedge clk); while (crc_pending != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d requests (%0d loads, %0d messages) over all eight mode codes,",
             requests_sent, loads_sent, frames_sent);
    $display("  %0d CRCs checked, with a long receiver hold-off and a gap-free stretch",
             crcs_checked);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
